[src/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions for the unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // most output bytes one input byte can produce
   localparam int unsigned MaxEmit = 5;
   localparam int unsigned EmitCntW = 3;

   // character codes
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChLowerU    = 8'h75;
   localparam logic [7:0] ChLowerB    = 8'h62;
   localparam logic [7:0] ChLowerF    = 8'h66;
   localparam logic [7:0] ChLowerN    = 8'h6E;
   localparam logic [7:0] ChLowerR    = 8'h72;
   localparam logic [7:0] ChLowerT    = 8'h74;
   localparam logic [7:0] CtlBackspace = 8'h08;
   localparam logic [7:0] CtlFormFeed  = 8'h0C;
   localparam logic [7:0] CtlNewline   = 8'h0A;
   localparam logic [7:0] CtlReturn    = 8'h0D;
   localparam logic [7:0] CtlTab       = 8'h09;

   // utf-8 limits and lead bits
   localparam logic [15:0] Utf8Max1 = 16'h007F;
   localparam logic [15:0] Utf8Max2 = 16'h07FF;
   localparam logic [7:0]  Utf8Lead2 = 8'hC0;
   localparam logic [7:0]  Utf8Lead3 = 8'hE0;
   localparam logic [7:0]  Utf8Cont  = 8'h80;

   // one group of output bytes from one input byte, lowest index first
   typedef struct packed {
      logic [MaxEmit-1:0][7:0] bytes;
      logic [EmitCntW-1:0]     count;
      logic                    last;
   } emit_rec_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // ascii hex digit decode, either case
   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.valid = 1'b1;
         r.value = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r.valid = 1'b1;
         r.value = b[3:0] + 4'd9;
      end
      return r;
   endfunction

   // single character escapes; anything else passes through
   function automatic logic [7:0] map_escape(input logic [7:0] e);
      logic [7:0] r;
      unique case (e)
         ChLowerB: r = CtlBackspace;
         ChLowerF: r = CtlFormFeed;
         ChLowerN: r = CtlNewline;
         ChLowerR: r = CtlReturn;
         ChLowerT: r = CtlTab;
         default:  r = e;
      endcase
      return r;
   endfunction

endpackage

[src/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks escape state and builds the group of
// output bytes each input byte produces.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 in_ready,
   input  logic                 q_ready,
   output logic                 q_push,
   output jsu_pkg::emit_rec_type q_rec
);
   import jsu_pkg::*;

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [1:0]          hex_count_ff, hex_count_in;
   logic [11:0]         code_accum_ff, code_accum_in;
   logic [2:0][7:0]     hex_chars_ff;
   logic                hex_we;
   logic                accept;
   hex_digit_type       digit;
   logic [15:0]         code;
   logic [2:0]          tail_pos;
   logic                tail_emit;

   assign accept   = in_valid & q_ready;
   assign in_ready = q_ready;
   assign q_push   = accept & (q_rec.count != '0);

   // classify the byte and build its output group
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_accum_in = code_accum_ff;
      hex_we        = 1'b0;
      tail_emit     = 1'b0;
      q_rec         = '0;
      q_rec.last    = in_last;
      digit         = hex_decode(in_byte);
      code          = {code_accum_ff, digit.value};
      tail_pos      = {1'b0, hex_count_ff} + 3'd1;

      unique case (mode_ff)
         MODE_ESCAPE: begin
            if (in_byte == ChLowerU && !in_last) begin
               mode_in       = MODE_HEX;
               hex_count_in  = '0;
               code_accum_in = '0;
            end else begin
               mode_in        = MODE_PLAIN;
               q_rec.bytes[0] = (in_byte == ChLowerU) ? ChLowerU : map_escape(in_byte);
               q_rec.count    = 3'd1;
            end
         end
         MODE_HEX: begin
            if (digit.valid && hex_count_ff == 2'd3) begin
               // fourth digit: encode as utf-8
               mode_in       = MODE_PLAIN;
               hex_count_in  = '0;
               code_accum_in = '0;
               if (code <= Utf8Max1) begin
                  q_rec.bytes[0] = code[7:0];
                  q_rec.count    = 3'd1;
               end else if (code <= Utf8Max2) begin
                  q_rec.bytes[0] = Utf8Lead2 | {3'b000, code[10:6]};
                  q_rec.bytes[1] = Utf8Cont | {2'b00, code[5:0]};
                  q_rec.count    = 3'd2;
               end else begin
                  q_rec.bytes[0] = Utf8Lead3 | {4'b0000, code[15:12]};
                  q_rec.bytes[1] = Utf8Cont | {2'b00, code[11:6]};
                  q_rec.bytes[2] = Utf8Cont | {2'b00, code[5:0]};
                  q_rec.count    = 3'd3;
               end
            end else if (digit.valid && !in_last) begin
               hex_we        = 1'b1;
               hex_count_in  = hex_count_ff + 2'd1;
               code_accum_in = code[11:0];
            end else begin
               // broken or cut short: 'u', digits so far, then this byte as plain
               mode_in        = MODE_PLAIN;
               hex_count_in   = '0;
               code_accum_in  = '0;
               q_rec.bytes[0] = ChLowerU;
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < hex_count_ff) q_rec.bytes[i+1] = hex_chars_ff[i];
               end
               if (in_byte == ChBackslash && !in_last) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  tail_emit = 1'b1;
               end
               for (int i = 1; i < MaxEmit; i++) begin
                  if (tail_emit && 3'(i) == tail_pos) q_rec.bytes[i] = in_byte;
               end
               q_rec.count = tail_pos + {2'b00, tail_emit};
            end
         end
         default: begin
            if (in_byte == ChBackslash && !in_last) begin
               mode_in = MODE_ESCAPE;
            end else begin
               mode_in        = MODE_PLAIN;
               q_rec.bytes[0] = in_byte;
               q_rec.count    = 3'd1;
            end
         end
      endcase

      // end of string always returns to plain text
      if (in_last) begin
         mode_in       = MODE_PLAIN;
         hex_count_in  = '0;
         code_accum_in = '0;
      end
   end

   // escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PLAIN;
         hex_count_ff  <= '0;
         code_accum_ff <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_accum_ff <= code_accum_in;
      end
   end

   // raw hex digit bytes, kept for literal replay
   always_ff @(posedge clock) begin
      if (accept && hex_we) begin
         hex_chars_ff[hex_count_ff] <= in_byte;
      end
   end

endmodule

[src/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Short register queue of output groups between classifier and serializer.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jsu_pkg::emit_rec_type push_rec,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 head_valid,
   output jsu_pkg::emit_rec_type head_rec
);
   import jsu_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   emit_rec_type          slots_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       fill_ff, fill_in;

   assign push_ready = (fill_ff != CntFull);
   assign head_valid = (fill_ff != '0);
   assign head_rec   = slots_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      if (push && !pop) fill_in = fill_ff + CntW'(1);
      if (pop && !push) fill_in = fill_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

[src/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Holds one output group and sends its bytes out one per transfer.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  jsu_pkg::emit_rec_type head_rec,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_byte,
   output logic                 out_last
);
   import jsu_pkg::*;

   emit_rec_type          rec_ff;
   logic                  busy_ff, busy_in;
   logic [EmitCntW-1:0]   idx_ff, idx_in;
   logic                  final_byte;
   logic                  done;

   assign final_byte = (idx_ff == rec_ff.count - EmitCntW'(1));
   assign done       = busy_ff & out_ready & final_byte;
   assign pop        = head_valid & (!busy_ff | done);

   assign out_valid = busy_ff;
   assign out_byte  = rec_ff.bytes[idx_ff];
   assign out_last  = rec_ff.last & final_byte;

   // byte index and occupancy
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
         idx_in  = '0;
      end else if (busy_ff && out_ready) begin
         idx_in = idx_ff + EmitCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // group being sent
   always_ff @(posedge clock) begin
      if (pop) rec_ff <= head_rec;
   end

endmodule

[src/json_string_unescaper_unit.sv]
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// A byte is offered on rsp after its req transfer has passed the queue
// slot and then the output register. Throughput: one input byte per cycle
// while each byte yields at most one output and rsp is not stalled; the
// output port sends one byte per cycle while rsp_tready is high, and a \u
// escape yields up to three and a broken escape up to five bytes on rsp.
// Reset: synchronous, clears escape state, queue and output; no clearing pass.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);
   import jsu_pkg::*;

   emit_rec_type push_rec;
   emit_rec_type head_rec;
   logic         q_push;
   logic         q_ready;
   logic         q_pop;
   logic         head_valid;

   // classifier
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_rec    (push_rec)
   );

   // decoupling queue
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (push_rec),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   // serializer
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

`ifndef SYNTHESIS
   // a final input byte always produces at least one output byte
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> (push_rec.count != '0))
      else $error("final byte produced no output group");

   // a push never lands on a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("push into full queue");

   // the serializer only takes a group the queue holds
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> head_valid)
      else $error("pop from empty queue");

   // every queued group carries one to five bytes
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push_rec.count != '0 && push_rec.count <= 3'd5))
      else $error("bad output group size");
`endif

endmodule

[tb/tb_json_string_unescaper_unit.sv]
// ----------------------------------------------------------------------------
// tb_json_string_unescaper_unit
// Drives JSON string body bytes into the unescaper and predicts every output
// byte with a local model of the escape decoder. Directed runs cover the byte
// extremes, the short escapes, \u escapes of two and three utf-8 bytes and
// the broken escapes. A random stream of mostly well-formed text follows.
// Both sides stall at random; results are checked in order at the rsp port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_json_string_unescaper_unit;
   import jsu_pkg::*;

   // cycles with no transfer on either side before the run is abandoned
   localparam int unsigned IdleLimit = 1000;
   localparam int unsigned RandomItems = 190;

   // characters used by the stimulus that the package does not name
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChLowerQ = 8'h71;
   localparam logic [7:0] ChDigit1 = 8'h31;
   localparam logic [7:0] ChDigit0 = 8'h30;
   localparam logic [7:0] ChLowerA = 8'h61;
   localparam logic [7:0] ChUpperA = 8'h41;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_HEX  = 2'd2
   } esc_mode_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   // predicted decoder state
   esc_mode_type esc_mode = MODE_TEXT;
   logic [2:0]   hex_cnt = '0;
   logic [15:0]  code_acc = '0;
   logic [7:0]   hex_bytes [3] = '{8'h00, 8'h00, 8'h00};
   int           step_n;

   out_beat_type unescaped_q [$];
   int           errors = 0;
   int           sent_count = 0;
   int           idle_cycles = 0;
   logic         calm = 1'b0;

   json_string_unescaper_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic int hex_val(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
      return -1;
   endfunction

   function automatic void emit(input logic [7:0] b);
      out_beat_type beat;
      beat.data = b;
      beat.last = 1'b0;
      unescaped_q.push_back(beat);
      step_n++;
   endfunction

   // plain text: a backslash opens an escape unless it ends the string
   function automatic void plain_text(input logic [7:0] b, input logic l);
      if (b == ChBackslash && !l) begin
         esc_mode = MODE_ESC;
      end else begin
         esc_mode = MODE_TEXT;
         emit(b);
      end
   endfunction

   // predicts the output bytes of one input byte and queues them
   function automatic void unescape_byte(input logic [7:0] b, input logic l);
      int          hv;
      logic [15:0] code;
      logic [7:0]  mapped;
      hv = hex_val(b);
      step_n = 0;
      case (esc_mode)
         MODE_ESC: begin
            if (b == ChLowerU) begin
               if (l) begin
                  esc_mode = MODE_TEXT;
                  emit(ChLowerU);
               end else begin
                  esc_mode = MODE_HEX;
                  hex_cnt = '0;
                  code_acc = '0;
               end
            end else begin
               case (b)
                  ChLowerB: mapped = CtlBackspace;
                  ChLowerF: mapped = CtlFormFeed;
                  ChLowerN: mapped = CtlNewline;
                  ChLowerR: mapped = CtlReturn;
                  ChLowerT: mapped = CtlTab;
                  default:  mapped = b;
               endcase
               esc_mode = MODE_TEXT;
               emit(mapped);
            end
         end
         MODE_HEX: begin
            if (hv >= 0 && hex_cnt == 3'd3) begin
               // fourth digit completes the code point
               code = {code_acc[11:0], 4'(hv)};
               esc_mode = MODE_TEXT;
               hex_cnt = '0;
               code_acc = '0;
               if (code <= Utf8Max1) begin
                  emit(code[7:0]);
               end else if (code <= Utf8Max2) begin
                  emit(Utf8Lead2 | {3'b000, code[10:6]});
                  emit(Utf8Cont | {2'b00, code[5:0]});
               end else begin
                  emit(Utf8Lead3 | {4'b0000, code[15:12]});
                  emit(Utf8Cont | {2'b00, code[11:6]});
                  emit(Utf8Cont | {2'b00, code[5:0]});
               end
            end else if (hv >= 0 && !l) begin
               hex_bytes[hex_cnt] = b;
               hex_cnt = hex_cnt + 3'd1;
               code_acc = {code_acc[11:0], 4'(hv)};
            end else begin
               // bad digit or early end: replay u and the digits, then the byte
               emit(ChLowerU);
               for (int k = 0; k < int'(hex_cnt); k++) emit(hex_bytes[k]);
               hex_cnt = '0;
               code_acc = '0;
               plain_text(b, l);
            end
         end
         default: plain_text(b, l);
      endcase
      if (l) begin
         esc_mode = MODE_TEXT;
         hex_cnt = '0;
         code_acc = '0;
         if (step_n > 0) unescaped_q[$].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return ChDigit0 + 8'(v);
      return ($urandom_range(0, 1) ? ChLowerA : ChUpperA) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (hex_val(b) >= 0) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // one req transfer; called and returns at a falling edge, valid left high
   task automatic send_raw_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= b;
      req_tlast  <= l;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      unescape_byte(b, l);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_unicode(input logic [15:0] code, input logic l);
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerU, 1'b0);
      send_raw_byte(hex_char(code[15:12]), 1'b0);
      send_raw_byte(hex_char(code[11:8]), 1'b0);
      send_raw_byte(hex_char(code[7:4]), 1'b0);
      send_raw_byte(hex_char(code[3:0]), l);
   endtask

   // sender holds off until the output side has caught up
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (unescaped_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_plain_extremes();
      send_raw_byte(8'h00, 1'b0);
      send_raw_byte(8'hFF, 1'b1);
   endtask

   task automatic test_short_escapes();
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerB, 1'b0);
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerF, 1'b0);
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerN, 1'b0);
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerR, 1'b0);
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerT, 1'b1);
   endtask

   task automatic test_unicode_escapes();
      // largest two byte code, then a surrogate ended on its fourth digit
      send_unicode(16'h07FF, 1'b0);
      send_unicode(16'hD800, 1'b1);
   endtask

   task automatic test_broken_escapes();
      // bad digit is a backslash that opens a fresh escape
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerU, 1'b0);
      send_raw_byte(ChDigit1, 1'b0);
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerN, 1'b0);
      // string ends right on the u
      send_raw_byte(ChBackslash, 1'b0);
      send_raw_byte(ChLowerU, 1'b1);
      // lone final backslash
      send_raw_byte(ChBackslash, 1'b1);
   endtask

   task automatic test_random_stream();
      int          base;
      int          kind;
      int          k;
      logic        tl;
      logic        early;
      logic        drained;
      logic [7:0]  b;
      logic [15:0] code;
      base = sent_count;
      drained = 1'b0;
      calm = 1'b0;
      while (sent_count - base < RandomItems) begin
         if ($urandom_range(0, 29) == 0) calm = ($urandom_range(0, 2) == 0);
         if (!drained && sent_count - base >= RandomItems / 2) begin
            wait_drained();
            drained = 1'b1;
         end
         kind = $urandom_range(0, 99);
         tl = ($urandom_range(0, 5) == 0);
         if (kind < 40) begin
            // plain text byte
            b = 8'($urandom_range(0, 255));
            if (b == ChBackslash) b = ChLowerQ;
            send_raw_byte(b, tl);
         end else if (kind < 55) begin
            // single character escape
            case ($urandom_range(0, 8))
               0: b = ChQuote;
               1: b = ChBackslash;
               2: b = ChSlash;
               3: b = ChLowerB;
               4: b = ChLowerF;
               5: b = ChLowerN;
               6: b = ChLowerR;
               7: b = ChLowerT;
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_raw_byte(ChBackslash, 1'b0);
            send_raw_byte(b, tl);
         end else if (kind < 75) begin
            // well-formed \u of each utf-8 length
            case ($urandom_range(0, 2))
               0: code = 16'($urandom_range(0, 16'h007F));
               1: code = 16'($urandom_range(16'h0080, 16'h07FF));
               default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            send_unicode(code, tl);
         end else if (kind < 85) begin
            // \u cut short by a bad digit or by the end of the string
            k = $urandom_range(0, 3);
            early = 1'($urandom_range(0, 1));
            send_raw_byte(ChBackslash, 1'b0);
            send_raw_byte(ChLowerU, early && k == 0);
            for (int i = 0; i < k; i++)
               send_raw_byte(hex_char(4'($urandom_range(0, 15))), early && i == k - 1);
            if (!early) send_raw_byte(non_hex_byte(), tl);
         end else if (kind < 90) begin
            send_raw_byte(ChBackslash, 1'b1);
         end else begin
            // noise
            send_raw_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // ------------------------------------------------------------ receiver

   // rsp_tready stalls a random number of cycles before each transfer
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // compare each rsp transfer with the oldest predicted byte
   always @(posedge clock) begin
      out_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (unescaped_q.size() == 0) begin
            $display("%0t unexpected output: byte %02h last %0b", $time, rsp_tdata,
                     rsp_tlast);
            errors++;
         end else begin
            want = unescaped_q.pop_front();
            if (rsp_tdata !== want.data) begin
               $display("%0t byte mismatch: expected %02h, actual %02h", $time,
                        want.data, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t last mismatch: expected %0b, actual %0b", $time,
                        want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_plain_extremes();
      test_short_escapes();
      test_unicode_escapes();
      test_broken_escapes();
      test_random_stream();

      req_tvalid <= 1'b0;
      while (unescaped_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[json_string_unescaper_unit.f]
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescaper_unit.sv
tb/tb_json_string_unescaper_unit.sv
